/* hw/rtl/cp2q_pkg.sv */
// Shared constants for the camera pose to quaternion converter.
// No dependencies. Used by the square root unit, the divider lanes and the top level.
package cp2q_pkg;

    // Square root unit: 64-bit radicand, 32-bit root, two radicand bits per step.
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int SQRT_PER    = 4;
    localparam int SQRT_STAGES = RAD_W / (2 * SQRT_PER);

    // Normalized magnitudes lie below 2^31.
    localparam int MAG_W = 31;

    // Quotient bits resolved in each divider stage.
    localparam int DIV_PER = 4;

endpackage

/* hw/rtl/cp2q_isqrt.sv */
// Pipelined floor integer square root, one root bit per step.
// Depends on cp2q_pkg. The caller owns the valid bits and drives one load enable per stage.
module cp2q_isqrt
    import cp2q_pkg::*;
(
    input  logic                     clk,
    input  logic [SQRT_STAGES-1:0]   adv,
    input  logic [RAD_W-1:0]         rad,
    output logic [ROOT_W-1:0]        root
);

    localparam int REM_W = ROOT_W + 3;

    logic [REM_W-1:0]  rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];
    logic [RAD_W-1:0]  rad_reg  [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [RAD_W-1:0]  rad_in;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;
            logic [RAD_W-1:0]  rad_next;

            // The first stage starts from an empty root and remainder.
            if (k == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = rad;
            end
            else begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign rad_in  = rad_reg[k-1];
            end

            // Bring down two radicand bits and try to subtract 4r+1.
            always_comb
            begin
                logic [REM_W-1:0]  rm;
                logic [REM_W-1:0]  rx;
                logic [REM_W-1:0]  trial;
                logic [ROOT_W-1:0] rt;
                logic [RAD_W-1:0]  rd;
                rm = rem_in;
                rt = root_in;
                rd = rad_in;
                for (int j = 0; j < SQRT_PER; j++)
                begin
                    rx    = {rm[REM_W-3:0], rd[RAD_W-1 -: 2]};
                    rd    = rd << 2;
                    trial = {1'b0, rt, 2'b01};
                    if (rx >= trial)
                    begin
                        rm = rx - trial;
                        rt = {rt[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rm = rx;
                        rt = {rt[ROOT_W-2:0], 1'b0};
                    end
                end
                rem_next  = rm;
                root_next = rt;
                rad_next  = rd;
            end

            always_ff @(posedge clk)
            begin
                if (adv[k])
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    rad_reg[k]  <= rad_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[SQRT_STAGES-1];

endmodule

/* hw/rtl/cp2q_div.sv */
// One pipelined restoring divider lane: round(mag * 2^UNIT_FRAC_BITS / n), halves up.
// Depends on cp2q_pkg. The caller owns the valid bits and drives one load enable per stage.
module cp2q_div
    import cp2q_pkg::*;
#(
    parameter int UNIT_FRAC_BITS = 30
)
(
    input  logic                                          clk,
    input  logic [(UNIT_FRAC_BITS+DIV_PER)/DIV_PER:0]     adv,
    input  logic [MAG_W-1:0]                              mag,
    input  logic [ROOT_W-1:0]                             n,
    output logic [MAG_W-1:0]                              quo
);

    localparam int DIV_BITS = UNIT_FRAC_BITS + 1;
    localparam int ITS      = (UNIT_FRAC_BITS + DIV_PER) / DIV_PER;
    localparam int DVD_W    = MAG_W + DIV_BITS;

    logic [DVD_W-1:0]    dvd_reg;
    logic [ROOT_W-1:0]   n0_reg;
    logic [ROOT_W-1:0]   rem_reg [ITS];
    logic [DIV_BITS-1:0] low_reg [ITS];
    logic [DIV_BITS-1:0] q_reg   [ITS];
    logic [ROOT_W-1:0]   n_reg   [ITS];

    // Dividend with the half-divisor added for rounding.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dvd_reg <= (DVD_W'(mag) << UNIT_FRAC_BITS) + DVD_W'(n >> 1);
            n0_reg  <= n;
        end
    end

    genvar k;
    generate
        for (k = 0; k < ITS; k++) begin : g_stage
            logic [ROOT_W-1:0]   rem_in;
            logic [DIV_BITS-1:0] low_in;
            logic [DIV_BITS-1:0] q_in;
            logic [ROOT_W-1:0]   n_in;
            logic [ROOT_W-1:0]   rem_next;
            logic [DIV_BITS-1:0] low_next;
            logic [DIV_BITS-1:0] q_next;

            // The quotient fits in DIV_BITS bits, so the top of the dividend is
            // already below the divisor and seeds the remainder.
            if (k == 0) begin : g_first
                assign rem_in = {1'b0, dvd_reg[DVD_W-1 -: MAG_W]};
                assign low_in = dvd_reg[DIV_BITS-1:0];
                assign q_in   = '0;
                assign n_in   = n0_reg;
            end
            else begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign low_in = low_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign n_in   = n_reg[k-1];
            end

            // One quotient bit per step.
            always_comb
            begin
                logic [ROOT_W-1:0]   rm;
                logic [ROOT_W:0]     rx;
                logic [DIV_BITS-1:0] lw;
                logic [DIV_BITS-1:0] qq;
                rm = rem_in;
                lw = low_in;
                qq = q_in;
                for (int j = 0; j < DIV_PER; j++)
                begin
                    if (k * DIV_PER + j < DIV_BITS)
                    begin
                        rx = {rm, lw[DIV_BITS-1]};
                        lw = lw << 1;
                        if (rx >= {1'b0, n_in})
                        begin
                            rm = ROOT_W'(rx - {1'b0, n_in});
                            qq = {qq[DIV_BITS-2:0], 1'b1};
                        end
                        else
                        begin
                            rm = rx[ROOT_W-1:0];
                            qq = {qq[DIV_BITS-2:0], 1'b0};
                        end
                    end
                end
                rem_next = rm;
                low_next = lw;
                q_next   = qq;
            end

            always_ff @(posedge clk)
            begin
                if (adv[k+1])
                begin
                    rem_reg[k] <= rem_next;
                    low_reg[k] <= low_next;
                    q_reg[k]   <= q_next;
                    n_reg[k]   <= n_in;
                end
            end
        end
    endgenerate

    assign quo = MAG_W'(q_reg[ITS-1]);

endmodule

/* hw/rtl/camera_pose_to_quaternion.sv */
// Camera pose to quaternion converter. One camera frame (right, up and forward
// vectors in Q2.30 and a position with 12 fraction bits) goes in per transaction and
// one result (unit quaternion with non-negative scalar part, plus the saturated
// world-to-camera translation) comes out per transaction. The pipeline takes a new
// transaction every cycle while item_stall is low, and it holds
// 23 + ceil((UNIT_FRAC_BITS + 1) / 4) transactions in flight (31 at the default). Its
// depth includes the eight-stage square root unit and the divider lanes that resolve four
// quotient bits per stage. A stall at the output holds only the stages that are full.
// Depends on cp2q_pkg, cp2q_isqrt and cp2q_div.
module camera_pose_to_quaternion
    import cp2q_pkg::*;
#(
    parameter int UNIT_FRAC_BITS = 30
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] right_x,
    input  logic signed [31:0] right_y,
    input  logic signed [31:0] right_z,
    input  logic signed [31:0] up_x,
    input  logic signed [31:0] up_y,
    input  logic signed [31:0] up_z,
    input  logic signed [31:0] fwd_x,
    input  logic signed [31:0] fwd_y,
    input  logic signed [31:0] fwd_z,
    input  logic signed [29:0] pos_x,
    input  logic signed [29:0] pos_y,
    input  logic signed [29:0] pos_z,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [30:0]        quat_w,
    output logic signed [31:0] quat_x,
    output logic signed [31:0] quat_y,
    output logic signed [31:0] quat_z,
    output logic signed [31:0] trans_x,
    output logic signed [31:0] trans_y,
    output logic signed [31:0] trans_z
);

    // Stage map.
    localparam int DIV_STG = (UNIT_FRAC_BITS + DIV_PER) / DIV_PER + 1;
    localparam int ST_A    = 0;
    localparam int ST_B    = 1;
    localparam int ST_C    = 2;
    localparam int ST_D    = 3;
    localparam int ST_E    = 4;
    localparam int ST_F    = 5;
    localparam int ST_G    = 6;
    localparam int ST_SQ   = 7;
    localparam int ST_DV   = ST_SQ + SQRT_STAGES;
    localparam int ST_Q    = ST_DV + DIV_STG;
    localparam int ST_P    = ST_Q + 1;
    localparam int ST_R1   = ST_Q + 2;
    localparam int ST_R2   = ST_Q + 3;
    localparam int ST_T    = ST_Q + 4;
    localparam int ST_ACC  = ST_Q + 5;
    localparam int ST_OUT  = ST_Q + 6;
    localparam int NS      = ST_OUT + 1;

    // Widths and constants.
    localparam int RW    = UNIT_FRAC_BITS + 4;
    localparam int TP_W  = RW + 31;
    localparam int ACC_W = RW + 33;
    localparam logic signed [34:0]      ONE_C  = 35'sd1 <<< UNIT_FRAC_BITS;
    localparam logic [31:0]             ONE_Q  = 32'd1 << UNIT_FRAC_BITS;
    localparam logic signed [65:0]      ONE2   = 66'sd1 <<< (2 * UNIT_FRAC_BITS);
    localparam logic [65:0]             HALF_R = 66'd1 << (UNIT_FRAC_BITS - 1);
    localparam logic [ACC_W-1:0]        HALF_A = ACC_W'(1) << (UNIT_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] T_LIM  = ACC_W'(1) << 30;

    // Valid bits and the ready chain: a stage loads when it is empty or draining.
    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;

    always_comb
    begin
        rdy[NS] = !result_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= item_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign item_stall   = !rdy[0];
    assign result_valid = v_reg[NS-1];

    // Stage A: mirrored rotation matrix, trace and mirrored centre.
    logic signed [32:0] m_next [9];
    logic signed [32:0] m_reg  [9];
    logic signed [34:0] tr_next;
    logic signed [34:0] tr_reg;
    logic [2:0][30:0]   ctr_next;
    logic [2:0][30:0]   ctr_reg [0:ST_R2];

    always_comb
    begin
        m_next[0] = -$signed({right_x[31], right_x});
        m_next[1] =  $signed({right_y[31], right_y});
        m_next[2] =  $signed({right_z[31], right_z});
        m_next[3] =  $signed({up_x[31], up_x});
        m_next[4] = -$signed({up_y[31], up_y});
        m_next[5] = -$signed({up_z[31], up_z});
        m_next[6] = -$signed({fwd_x[31], fwd_x});
        m_next[7] =  $signed({fwd_y[31], fwd_y});
        m_next[8] =  $signed({fwd_z[31], fwd_z});
        tr_next   = 35'(m_next[0]) + 35'(m_next[4]) + 35'(m_next[8]);
        ctr_next[0] = 31'(-$signed({pos_x[29], pos_x}));
        ctr_next[1] = {pos_y[29], pos_y};
        ctr_next[2] = {pos_z[29], pos_z};
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_A])
        begin
            m_reg  <= m_next;
            tr_reg <= tr_next;
        end
    end

    // Stage B: pick the trace branch and form the unnormalized quaternion.
    logic signed [34:0] c_next [4];
    logic signed [34:0] c_reg  [4];

    always_comb
    begin
        logic signed [34:0] e [9];
        for (int i = 0; i < 9; i++)
        begin
            e[i] = 35'(m_reg[i]);
        end
        if (tr_reg > 0)
        begin
            c_next[0] = tr_reg + ONE_C;
            c_next[1] = e[7] - e[5];
            c_next[2] = e[2] - e[6];
            c_next[3] = e[3] - e[1];
        end
        else if (m_reg[0] > m_reg[4] && m_reg[0] > m_reg[8])
        begin
            c_next[0] = e[7] - e[5];
            c_next[1] = ONE_C + e[0] - e[4] - e[8];
            c_next[2] = e[1] + e[3];
            c_next[3] = e[2] + e[6];
        end
        else if (m_reg[4] > m_reg[8])
        begin
            c_next[0] = e[2] - e[6];
            c_next[1] = e[1] + e[3];
            c_next[2] = ONE_C + e[4] - e[0] - e[8];
            c_next[3] = e[5] + e[7];
        end
        else
        begin
            c_next[0] = e[3] - e[1];
            c_next[1] = e[2] + e[6];
            c_next[2] = e[5] + e[7];
            c_next[3] = ONE_C + e[8] - e[0] - e[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_B])
        begin
            c_reg <= c_next;
        end
    end

    // Stage C: magnitudes, signs and the largest magnitude.
    logic [33:0] cm_next [4];
    logic [33:0] cm_reg  [4];
    logic [33:0] mx_next;
    logic [33:0] mx_reg;
    logic [4:0]  nz_next;
    logic [4:0]  nz_reg [ST_C:ST_Q-1];

    always_comb
    begin
        logic [33:0] mx01;
        logic [33:0] mx23;
        for (int i = 0; i < 4; i++)
        begin
            cm_next[i] = c_reg[i][34] ? 34'(-c_reg[i]) : 34'(c_reg[i]);
            nz_next[i] = c_reg[i][34];
        end
        mx01    = (cm_next[0] > cm_next[1]) ? cm_next[0] : cm_next[1];
        mx23    = (cm_next[2] > cm_next[3]) ? cm_next[2] : cm_next[3];
        mx_next = (mx01 > mx23) ? mx01 : mx23;
        nz_next[4] = (mx_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_C])
        begin
            cm_reg <= cm_next;
            mx_reg <= mx_next;
        end
    end

    // Stage D: leading one of the largest magnitude.
    logic [33:0] dm_reg [4];
    logic [5:0]  msb_next;
    logic [5:0]  msb_reg;

    always_comb
    begin
        msb_next = '0;
        for (int i = 0; i < 34; i++)
        begin
            if (mx_reg[i])
            begin
                msb_next = 6'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_D])
        begin
            dm_reg  <= cm_reg;
            msb_reg <= msb_next;
        end
    end

    // Stage E: scale so that the largest magnitude sits in [2^30, 2^31).
    logic [MAG_W-1:0] sm_next [4];
    logic [MAG_W-1:0] sm_reg  [ST_E:ST_DV-1][4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (msb_reg > 6'd30)
            begin
                sm_next[i] = MAG_W'(dm_reg[i] >> (msb_reg - 6'd30));
            end
            else
            begin
                sm_next[i] = MAG_W'(dm_reg[i] << (6'd30 - msb_reg));
            end
        end
    end

    // Stage F: squares.
    logic [61:0] sq_reg [4];

    always_ff @(posedge clk)
    begin
        if (rdy[ST_F])
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i] <= 62'(sm_reg[ST_E][i]) * 62'(sm_reg[ST_E][i]);
            end
        end
    end

    // Stage G: sum of squares.
    logic [RAD_W-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_G])
        begin
            sum_reg <= RAD_W'(sq_reg[0]) + RAD_W'(sq_reg[1])
                     + RAD_W'(sq_reg[2]) + RAD_W'(sq_reg[3]);
        end
    end

    // Norm, then one divider lane per quaternion part.
    logic [ROOT_W-1:0] norm;
    logic [MAG_W-1:0]  quo [4];

    cp2q_isqrt u_isqrt
    (
        .clk  (clk),
        .adv  (rdy[ST_SQ +: SQRT_STAGES]),
        .rad  (sum_reg),
        .root (norm)
    );

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            cp2q_div #(
                .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
            ) u_div
            (
                .clk (clk),
                .adv (rdy[ST_DV +: DIV_STG]),
                .mag (sm_reg[ST_DV-1][g]),
                .n   (norm),
                .quo (quo[g])
            );
        end
    endgenerate

    // Stage Q: restore signs with a non-negative scalar part; degenerate input
    // gives the identity.
    logic signed [31:0] q_next [4];
    logic signed [31:0] qc_reg [ST_Q:ST_OUT][4];

    always_comb
    begin
        logic [4:0] nz;
        nz = nz_reg[ST_Q-1];
        if (nz[4])
        begin
            q_next[0] = ONE_Q;
            q_next[1] = '0;
            q_next[2] = '0;
            q_next[3] = '0;
        end
        else
        begin
            q_next[0] = {1'b0, quo[0]};
            for (int i = 1; i < 4; i++)
            begin
                q_next[i] = (nz[i] ^ nz[0]) ? -$signed({1'b0, quo[i]})
                                            : $signed({1'b0, quo[i]});
            end
        end
    end

    // Stage P: quaternion products (xx, yy, zz, xy, xz, yz, xw, yw, zw).
    logic signed [63:0] pr_reg [9];

    always_ff @(posedge clk)
    begin
        if (rdy[ST_P])
        begin
            pr_reg[0] <= 64'(qc_reg[ST_Q][1]) * 64'(qc_reg[ST_Q][1]);
            pr_reg[1] <= 64'(qc_reg[ST_Q][2]) * 64'(qc_reg[ST_Q][2]);
            pr_reg[2] <= 64'(qc_reg[ST_Q][3]) * 64'(qc_reg[ST_Q][3]);
            pr_reg[3] <= 64'(qc_reg[ST_Q][1]) * 64'(qc_reg[ST_Q][2]);
            pr_reg[4] <= 64'(qc_reg[ST_Q][1]) * 64'(qc_reg[ST_Q][3]);
            pr_reg[5] <= 64'(qc_reg[ST_Q][2]) * 64'(qc_reg[ST_Q][3]);
            pr_reg[6] <= 64'(qc_reg[ST_Q][1]) * 64'(qc_reg[ST_Q][0]);
            pr_reg[7] <= 64'(qc_reg[ST_Q][2]) * 64'(qc_reg[ST_Q][0]);
            pr_reg[8] <= 64'(qc_reg[ST_Q][3]) * 64'(qc_reg[ST_Q][0]);
        end
    end

    // Stage R1: rotation entries at twice the fraction bits.
    logic signed [65:0] rs_next [9];
    logic signed [65:0] rs_reg  [9];

    always_comb
    begin
        logic signed [65:0] p [9];
        for (int i = 0; i < 9; i++)
        begin
            p[i] = 66'(pr_reg[i]);
        end
        rs_next[0] = ONE2 - ((p[1] + p[2]) <<< 1);
        rs_next[1] = (p[3] - p[8]) <<< 1;
        rs_next[2] = (p[4] + p[7]) <<< 1;
        rs_next[3] = (p[3] + p[8]) <<< 1;
        rs_next[4] = ONE2 - ((p[0] + p[2]) <<< 1);
        rs_next[5] = (p[5] - p[6]) <<< 1;
        rs_next[6] = (p[4] - p[7]) <<< 1;
        rs_next[7] = (p[5] + p[6]) <<< 1;
        rs_next[8] = ONE2 - ((p[0] + p[1]) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_R1])
        begin
            rs_reg <= rs_next;
        end
    end

    // Stage R2: round the rotation entries, halves away from zero.
    logic signed [RW-1:0] rr_next [9];
    logic signed [RW-1:0] rr_reg  [9];

    always_comb
    begin
        logic [65:0] rmag;
        for (int i = 0; i < 9; i++)
        begin
            rmag = rs_reg[i][65] ? 66'(-rs_reg[i]) : 66'(rs_reg[i]);
            rmag = (rmag + HALF_R) >> UNIT_FRAC_BITS;
            rr_next[i] = rs_reg[i][65] ? -$signed(RW'(rmag)) : $signed(RW'(rmag));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_R2])
        begin
            rr_reg <= rr_next;
        end
    end

    // Stage T: rotation times mirrored centre, one product per entry.
    logic signed [TP_W-1:0] tp_reg [9];

    always_ff @(posedge clk)
    begin
        if (rdy[ST_T])
        begin
            for (int i = 0; i < 9; i++)
            begin
                tp_reg[i] <= TP_W'(rr_reg[i]) * TP_W'($signed(ctr_reg[ST_R2][i % 3]));
            end
        end
    end

    // Stage ACC: row sums.
    logic signed [ACC_W-1:0] acc_reg [3];

    always_ff @(posedge clk)
    begin
        if (rdy[ST_ACC])
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= ACC_W'(tp_reg[3*i]) + ACC_W'(tp_reg[3*i+1])
                            + ACC_W'(tp_reg[3*i+2]);
            end
        end
    end

    // Stage OUT: round, negate and saturate the translation.
    logic signed [31:0] trans_next [3];
    logic signed [31:0] trans_reg  [3];

    always_comb
    begin
        logic [ACC_W-1:0]        amag;
        logic signed [ACC_W-1:0] t;
        for (int i = 0; i < 3; i++)
        begin
            amag = acc_reg[i][ACC_W-1] ? ACC_W'(-acc_reg[i]) : ACC_W'(acc_reg[i]);
            amag = (amag + HALF_A) >> UNIT_FRAC_BITS;
            t    = acc_reg[i][ACC_W-1] ? $signed(amag) : -$signed(amag);
            if (t > T_LIM)
            begin
                t = T_LIM;
            end
            else if (t < -T_LIM)
            begin
                t = -T_LIM;
            end
            trans_next[i] = 32'(t);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_OUT])
        begin
            trans_reg <= trans_next;
        end
    end

    // Side data that travels with each transaction.
    always_ff @(posedge clk)
    begin
        if (rdy[ST_A])
        begin
            ctr_reg[0] <= ctr_next;
        end
        for (int k = 1; k <= ST_R2; k++)
        begin
            if (rdy[k])
            begin
                ctr_reg[k] <= ctr_reg[k-1];
            end
        end

        if (rdy[ST_C])
        begin
            nz_reg[ST_C] <= nz_next;
        end
        for (int k = ST_C + 1; k < ST_Q; k++)
        begin
            if (rdy[k])
            begin
                nz_reg[k] <= nz_reg[k-1];
            end
        end

        if (rdy[ST_E])
        begin
            sm_reg[ST_E] <= sm_next;
        end
        for (int k = ST_E + 1; k < ST_DV; k++)
        begin
            if (rdy[k])
            begin
                sm_reg[k] <= sm_reg[k-1];
            end
        end

        if (rdy[ST_Q])
        begin
            qc_reg[ST_Q] <= q_next;
        end
        for (int k = ST_Q + 1; k <= ST_OUT; k++)
        begin
            if (rdy[k])
            begin
                qc_reg[k] <= qc_reg[k-1];
            end
        end
    end

    // Result ports.
    assign quat_w  = qc_reg[ST_OUT][0][30:0];
    assign quat_x  = qc_reg[ST_OUT][1];
    assign quat_y  = qc_reg[ST_OUT][2];
    assign quat_z  = qc_reg[ST_OUT][3];
    assign trans_x = trans_reg[0];
    assign trans_y = trans_reg[1];
    assign trans_z = trans_reg[2];

endmodule

/* test/testbench.sv */
// Self-checking testbench for the camera pose to quaternion converter.
// Depends on cp2q_pkg and camera_pose_to_quaternion; it predicts each result itself.
// Directed frames come first, then random frames under varying flow control.
`timescale 1ns / 100ps

module testbench;
    import cp2q_pkg::*;

    localparam longint ONE = 64'sd1 << 30;
    localparam longint TRANS_MAX = 64'sd1 << 30;
    localparam int RANDOM_FRAMES = 1900;
    localparam int MAX_ITEMS = 2048;
    localparam int MAX_ROWS = 16;

    typedef struct {
        logic signed [31:0] rx, ry, rz, ux, uy, uz, fx, fy, fz;
        logic signed [29:0] px, py, pz;
    } frame_t;

    typedef struct {
        logic [30:0]        w;
        logic signed [31:0] x, y, z, tx, ty, tz;
    } pose_t;

    typedef struct {
        frame_t f;
        bit     known;
        pose_t  res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic signed [31:0] right_x = '0, right_y = '0, right_z = '0;
    logic signed [31:0] up_x = '0, up_y = '0, up_z = '0;
    logic signed [31:0] fwd_x = '0, fwd_y = '0, fwd_z = '0;
    logic signed [29:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [30:0] quat_w;
    logic signed [31:0] quat_x, quat_y, quat_z, trans_x, trans_y, trans_z;

    // Expected results in send order; the receiver walks them with its own index.
    pose_t exp_poses[MAX_ITEMS];
    int n_sent = 0;
    int n_checked = 0;
    dir_row_t dir_rows[MAX_ROWS];
    int n_rows = 0;
    int fails = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;

    camera_pose_to_quaternion u_top (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .right_x(right_x), .right_y(right_y), .right_z(right_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z),
        .fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .result_valid(result_valid), .result_stall(result_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z)
    );

    // Clock with a 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Floor integer square root.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Drop 30 fraction bits, rounding halves away from zero.
    function automatic longint round_q30(longint v);
        longint unsigned a;
        a = (v < 0) ? longint'(-v) : v;
        a = (a + (64'd1 << 29)) >> 30;
        return (v < 0) ? -longint'(a) : longint'(a);
    endfunction

    // Expected quaternion and translation for one camera frame.
    function automatic pose_t pose_of_frame(frame_t f);
        longint m[9], c[4], q[4], r[9], ctr[3];
        longint trace, acc, t;
        longint unsigned mg[4], big, sum, nrm, qm;
        int sr, sl;
        pose_t p;
        m[0] = -longint'(f.rx); m[1] = longint'(f.ry);  m[2] = longint'(f.rz);
        m[3] = longint'(f.ux);  m[4] = -longint'(f.uy); m[5] = -longint'(f.uz);
        m[6] = -longint'(f.fx); m[7] = longint'(f.fy);  m[8] = longint'(f.fz);
        ctr[0] = -longint'(f.px);
        ctr[1] = longint'(f.py);
        ctr[2] = longint'(f.pz);

        // Pick the trace branch or the largest diagonal element.
        trace = m[0] + m[4] + m[8];
        if (trace > 0)
        begin
            c[0] = trace + ONE; c[1] = m[7] - m[5]; c[2] = m[2] - m[6]; c[3] = m[3] - m[1];
        end
        else if (m[0] > m[4] && m[0] > m[8])
        begin
            c[0] = m[7] - m[5]; c[1] = ONE + m[0] - m[4] - m[8];
            c[2] = m[1] + m[3]; c[3] = m[2] + m[6];
        end
        else if (m[4] > m[8])
        begin
            c[0] = m[2] - m[6]; c[1] = m[1] + m[3];
            c[2] = ONE + m[4] - m[0] - m[8]; c[3] = m[5] + m[7];
        end
        else
        begin
            c[0] = m[3] - m[1]; c[1] = m[2] + m[6];
            c[2] = m[5] + m[7]; c[3] = ONE + m[8] - m[0] - m[4];
        end

        // Normalize on the magnitudes, then restore the signs.
        big = 0;
        for (int i = 0; i < 4; i++)
        begin
            mg[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
            if (mg[i] > big)
                big = mg[i];
        end
        if (big == 0)
        begin
            q[0] = ONE; q[1] = 0; q[2] = 0; q[3] = 0;
        end
        else
        begin
            sr = 0;
            sl = 0;
            while ((big >> sr) >= (64'd1 << 31))
                sr++;
            while ((big << sl) < (64'd1 << 30))
                sl++;
            sum = 0;
            for (int i = 0; i < 4; i++)
            begin
                mg[i] = (mg[i] >> sr) << sl;
                sum += mg[i] * mg[i];
            end
            nrm = floor_sqrt(sum);
            for (int i = 0; i < 4; i++)
            begin
                qm = (mg[i] * longint'(ONE) + nrm / 2) / nrm;
                q[i] = (c[i] < 0) ? -longint'(qm) : longint'(qm);
            end
            if (c[0] < 0)
                for (int i = 0; i < 4; i++)
                    q[i] = -q[i];
        end

        // Rebuild the rotation from the quaternion.
        r[0] = (ONE << 30) - 2 * (q[2] * q[2] + q[3] * q[3]);
        r[1] = 2 * (q[1] * q[2] - q[3] * q[0]);
        r[2] = 2 * (q[1] * q[3] + q[2] * q[0]);
        r[3] = 2 * (q[1] * q[2] + q[3] * q[0]);
        r[4] = (ONE << 30) - 2 * (q[1] * q[1] + q[3] * q[3]);
        r[5] = 2 * (q[2] * q[3] - q[1] * q[0]);
        r[6] = 2 * (q[1] * q[3] - q[2] * q[0]);
        r[7] = 2 * (q[2] * q[3] + q[1] * q[0]);
        r[8] = (ONE << 30) - 2 * (q[1] * q[1] + q[2] * q[2]);
        for (int i = 0; i < 9; i++)
            r[i] = round_q30(r[i]);

        p.w = q[0][30:0];
        p.x = q[1][31:0];
        p.y = q[2][31:0];
        p.z = q[3][31:0];

        // Translation is minus the rotation times the mirrored centre, saturated.
        for (int i = 0; i < 3; i++)
        begin
            acc = r[i * 3] * ctr[0] + r[i * 3 + 1] * ctr[1] + r[i * 3 + 2] * ctr[2];
            t = -round_q30(acc);
            if (t > TRANS_MAX)
                t = TRANS_MAX;
            if (t < -TRANS_MAX)
                t = -TRANS_MAX;
            if (i == 0)
                p.tx = t[31:0];
            else if (i == 1)
                p.ty = t[31:0];
            else
                p.tz = t[31:0];
        end
        return p;
    endfunction

    // Offer one frame, optionally after some idle cycles, and wait for acceptance.
    task automatic send_frame(frame_t f, int gap, bit known, pose_t res);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        right_x <= f.rx; right_y <= f.ry; right_z <= f.rz;
        up_x <= f.ux; up_y <= f.uy; up_z <= f.uz;
        fwd_x <= f.fx; fwd_y <= f.fy; fwd_z <= f.fz;
        pos_x <= f.px; pos_y <= f.py; pos_z <= f.pz;
        forever
        begin
            @(posedge clk);
            if (!item_stall)
                break;
        end
        exp_poses[n_sent] = known ? res : pose_of_frame(f);
        n_sent++;
    endtask

    function automatic logic signed [31:0] unit_component();
        int pick;
        pick = $urandom_range(9, 0);
        if (pick == 0)
            return $urandom;
        return 32'(longint'($urandom_range(32'h8000_0000, 0)) - ONE);
    endfunction

    function automatic logic signed [29:0] pos_component();
        logic [31:0] raw;
        if ($urandom_range(9, 0) == 0)
        begin
            raw = $urandom;
            return raw[29:0];
        end
        return 30'(longint'($urandom_range(819200000, 0)) - 409600000);
    endfunction

    // Mostly signed axis permutations, sometimes slightly perturbed, else noise.
    function automatic frame_t random_frame();
        frame_t f;
        int perm[3];
        longint rows[3][3];
        int tmp, k;
        f.px = pos_component();
        f.py = pos_component();
        f.pz = pos_component();
        if ($urandom_range(3, 0) == 0)
        begin
            f.rx = unit_component(); f.ry = unit_component(); f.rz = unit_component();
            f.ux = unit_component(); f.uy = unit_component(); f.uz = unit_component();
            f.fx = unit_component(); f.fy = unit_component(); f.fz = unit_component();
            return f;
        end
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--)
        begin
            k = $urandom_range(i, 0);
            tmp = perm[i];
            perm[i] = perm[k];
            perm[k] = tmp;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                rows[i][j] = (perm[i] == j) ? (($urandom_range(1, 0) != 0) ? ONE : -ONE) : 0;
                if ($urandom_range(1, 0) != 0)
                    rows[i][j] += longint'($urandom_range(32'h0080_0000, 0)) - (64'sd1 << 22);
            end
        f.rx = 32'(rows[0][0]); f.ry = 32'(rows[0][1]); f.rz = 32'(rows[0][2]);
        f.ux = 32'(rows[1][0]); f.uy = 32'(rows[1][1]); f.uz = 32'(rows[1][2]);
        f.fx = 32'(rows[2][0]); f.fy = 32'(rows[2][1]); f.fz = 32'(rows[2][2]);
        return f;
    endfunction

    function automatic frame_t make_frame(longint rx, longint ry, longint rz, longint ux,
                                          longint uy, longint uz, longint fx, longint fy,
                                          longint fz, longint px, longint py, longint pz);
        frame_t f;
        f.rx = 32'(rx); f.ry = 32'(ry); f.rz = 32'(rz);
        f.ux = 32'(ux); f.uy = 32'(uy); f.uz = 32'(uz);
        f.fx = 32'(fx); f.fy = 32'(fy); f.fz = 32'(fz);
        f.px = 30'(px); f.py = 30'(py); f.pz = 30'(pz);
        return f;
    endfunction

    function automatic pose_t pose_from_fields(longint w, longint x, longint y, longint z,
                                               longint tx, longint ty, longint tz);
        pose_t p;
        p.w = 31'(w); p.x = 32'(x); p.y = 32'(y); p.z = 32'(z);
        p.tx = 32'(tx); p.ty = 32'(ty); p.tz = 32'(tz);
        return p;
    endfunction

    function automatic void add_row(frame_t f, bit known, pose_t res);
        dir_row_t row;
        row.f = f;
        row.known = known;
        row.res = res;
        dir_rows[n_rows] = row;
        n_rows++;
    endfunction

    // Receiver: check each accepted result, then decide the next stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (n_checked >= n_sent)
                begin
                    $error("unexpected result transaction");
                    fails++;
                end
                else
                begin
                    pose_t e;
                    e = exp_poses[n_checked];
                    n_checked++;
                    if (quat_w !== e.w)
                    begin
                        $error("quat_w expected %0d got %0d", e.w, quat_w); fails++;
                    end
                    if (quat_x !== e.x)
                    begin
                        $error("quat_x expected %0d got %0d", e.x, quat_x); fails++;
                    end
                    if (quat_y !== e.y)
                    begin
                        $error("quat_y expected %0d got %0d", e.y, quat_y); fails++;
                    end
                    if (quat_z !== e.z)
                    begin
                        $error("quat_z expected %0d got %0d", e.z, quat_z); fails++;
                    end
                    if (trans_x !== e.tx)
                    begin
                        $error("trans_x expected %0d got %0d", e.tx, trans_x); fails++;
                    end
                    if (trans_y !== e.ty)
                    begin
                        $error("trans_y expected %0d got %0d", e.ty, trans_y); fails++;
                    end
                    if (trans_z !== e.tz)
                    begin
                        $error("trans_z expected %0d got %0d", e.tz, trans_z); fails++;
                    end
                end
            end
            if (hold_req && !hold_taken)
            begin
                hold_taken <= 1'b1;
                hold_left <= 400;
                result_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // Main stimulus.
    initial
    begin
        pose_t none;
        int waited;
        none = pose_from_fields(0, 0, 0, 0, 0, 0, 0);

        // Directed frames: degenerate, axis-aligned branches, extremes.
        add_row(make_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                pose_from_fields(0, 0, 0, ONE, 0, 0, 0));
        add_row(make_frame(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE, 4096, 8192, -4096), 1,
                pose_from_fields(ONE, 0, 0, 0, 4096, -8192, 4096));
        add_row(make_frame(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE, 409600000, 409600000,
                           -409600000), 1,
                pose_from_fields(ONE, 0, 0, 0, 409600000, -409600000, 409600000));
        add_row(make_frame(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0), 1,
                pose_from_fields(0, 0, 0, ONE, 0, 0, 0));
        add_row(make_frame(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE, 0, 0, 0), 1,
                pose_from_fields(0, ONE, 0, 0, 0, 0, 0));
        add_row(make_frame(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, 0, 0, 0), 1,
                pose_from_fields(0, 0, ONE, 0, 0, 0, 0));
        add_row(make_frame(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE, 1000, -2000, 3000), 0, none);
        add_row(make_frame(0, 0, ONE, 0, ONE, 0, -ONE, 0, 0, -409600000, 409600000,
                           409600000), 0, none);
        add_row(make_frame(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE,
                           409600000, 409600000, 409600000), 0, none);
        add_row(make_frame(-ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE,
                           -409600000, -409600000, -409600000), 0, none);
        add_row(make_frame(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                           32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                           32'sh7fff_ffff, 30'sh1fff_ffff, 30'sh1fff_ffff,
                           30'sh1fff_ffff), 0, none);
        add_row(make_frame(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                           -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                           -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                           -30'sh2000_0000, -30'sh2000_0000, -30'sh2000_0000), 0, none);
        add_row(make_frame(-ONE, 0, 0, 0, 0, ONE, 0, ONE, 0, -1, 1, -1), 0, none);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < n_rows; i++)
            send_frame(dir_rows[i].f, 0, dir_rows[i].known, dir_rows[i].res);

        // Random frames in three flow-control phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 0)
            begin
                send_idle_pct <= 10;
                stall_pct <= 74;
            end
            else if (phase == 1)
            begin
                send_idle_pct <= 74;
                stall_pct <= 10;
            end
            else
            begin
                send_idle_pct <= 0;
                stall_pct <= 0;
                hold_req <= 1'b1;
            end
            for (int n = 0; n < RANDOM_FRAMES / 3; n++)
            begin
                int gap;
                // Each idle cycle is drawn on its own, so the idle share matches the rate.
                gap = 0;
                while ($urandom_range(99, 0) < send_idle_pct)
                    gap++;
                send_frame(random_frame(), gap, 0, none);
            end
        end
        item_valid <= 1'b0;

        // Drain, then let the pipeline settle.
        waited = 0;
        while (n_checked != n_sent && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        if (fails == 0 && n_checked == n_sent)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #4ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
